@@ rtl/core/afp_pkg.sv @@
// Shared types and constants of the angle frame parser.
package afp_pkg;

    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int ANGLE_W = 24;
    localparam int TEMP_W  = 10;
    localparam int NUM_DATA_BYTES = 8;
    localparam int IDX_W   = $clog2(NUM_DATA_BYTES);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE = 1'd1;
    localparam logic [BYTE_W-1:0] TYPE_BYTE_RESET = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'h55;

    // Angle scale: degrees in Q15 is the raw value times 180.
    localparam logic signed [8:0] ANGLE_SCALE = 9'sd180;

    // Temperature divide by 100 as a multiply by ceil(2^19 / 100) and a shift.
    // Exact for magnitudes up to 32768.
    localparam int TEMP_SHIFT = 19;
    localparam int TEMP_RECIP_W = 13;
    localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = 13'd5243;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_CHECK
    } parse_state_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] roll;
        logic signed [RAW_W-1:0] pitch;
        logic signed [RAW_W-1:0] yaw;
        logic signed [RAW_W-1:0] temp;
    } frame_t;

    typedef struct packed {
        logic byte_take;
        logic frame_valid;
    } frm_status_t;

endpackage

@@ rtl/core/afp_frame.sv @@
// Frame collection, checksum check and the register that holds a good frame.
module afp_frame (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic [afp_pkg::BYTE_W-1:0]  byte_data,
    input  logic [afp_pkg::BYTE_W-1:0]  type_byte,
    input  logic [afp_pkg::BYTE_W-1:0]  sync_byte,
    input  logic                        frame_take,
    output afp_pkg::frm_status_t        status,
    output afp_pkg::frame_t             frame
);
    import afp_pkg::*;

    parse_state_t      state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] data_reg [NUM_DATA_BYTES];
    logic              frm_v_reg, frm_v_next;
    frame_t            frm_reg;

    logic frm_free;
    logic byte_take;
    logic do_start;
    logic do_store;
    logic do_check;
    logic load;

    assign frm_free  = !frm_v_reg || frame_take;
    assign byte_take = byte_valid && frm_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (byte_take)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (byte_data == type_byte)
                    begin
                        state_next = ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (idx_reg == IDX_W'(NUM_DATA_BYTES - 1))
                    begin
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Per-state actions on the byte being taken.
    always_comb
    begin
        do_start = 1'b0;
        do_store = 1'b0;
        do_check = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                do_start = byte_take && (byte_data == type_byte);
            end
            ST_DATA:
            begin
                do_store = byte_take;
            end
            ST_CHECK:
            begin
                do_check = byte_take;
            end
            default:
            begin
                do_check = byte_take;
            end
        endcase
    end

    assign load = do_check && (byte_data == sum_reg);

    always_comb
    begin
        frm_v_next = frm_v_reg;
        if (load)
        begin
            frm_v_next = 1'b1;
        end
        else if (frame_take)
        begin
            frm_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            sum_reg   <= '0;
            frm_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frm_v_reg <= frm_v_next;
            if (do_start)
            begin
                idx_reg <= '0;
                sum_reg <= sync_byte + byte_data;
            end
            else if (do_store)
            begin
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_reg + byte_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            data_reg[idx_reg] <= byte_data;
        end
        if (load)
        begin
            frm_reg.roll  <= {data_reg[1], data_reg[0]};
            frm_reg.pitch <= {data_reg[3], data_reg[2]};
            frm_reg.yaw   <= {data_reg[5], data_reg[4]};
            frm_reg.temp  <= {data_reg[7], data_reg[6]};
        end
    end

    assign status.byte_take   = byte_take;
    assign status.frame_valid = frm_v_reg;
    assign frame              = frm_reg;

endmodule

@@ rtl/core/afp_scale.sv @@
// Conversion of a raw frame into scaled angles and whole-degree temperature.
module afp_scale (
    input  afp_pkg::frame_t                    frame,
    output logic signed [afp_pkg::ANGLE_W-1:0] roll_q15,
    output logic signed [afp_pkg::ANGLE_W-1:0] pitch_q15,
    output logic signed [afp_pkg::ANGLE_W-1:0] yaw_q15,
    output logic signed [afp_pkg::TEMP_W-1:0]  temp_degrees
);
    import afp_pkg::*;

    logic signed [ANGLE_W:0] roll_full;
    logic signed [ANGLE_W:0] pitch_full;
    logic signed [ANGLE_W:0] yaw_full;

    logic                               temp_neg;
    logic signed [RAW_W:0]              temp_ext;
    logic [RAW_W:0]                     temp_mag;
    logic [RAW_W+TEMP_RECIP_W:0]        temp_prod;
    logic [TEMP_W-1:0]                  quot_mag;

    assign roll_full  = (ANGLE_W+1)'(frame.roll)  * (ANGLE_W+1)'(ANGLE_SCALE);
    assign pitch_full = (ANGLE_W+1)'(frame.pitch) * (ANGLE_W+1)'(ANGLE_SCALE);
    assign yaw_full   = (ANGLE_W+1)'(frame.yaw)   * (ANGLE_W+1)'(ANGLE_SCALE);

    assign roll_q15  = roll_full[ANGLE_W-1:0];
    assign pitch_q15 = pitch_full[ANGLE_W-1:0];
    assign yaw_q15   = yaw_full[ANGLE_W-1:0];

    // Truncating division works on the magnitude, then the sign is put back.
    assign temp_neg  = frame.temp[RAW_W-1];
    assign temp_ext  = {frame.temp[RAW_W-1], frame.temp};
    assign temp_mag  = temp_neg ? (RAW_W+1)'(-temp_ext) : temp_ext;
    assign temp_prod = (RAW_W+TEMP_RECIP_W+1)'(temp_mag)
                     * (RAW_W+TEMP_RECIP_W+1)'(TEMP_RECIP);
    assign quot_mag  = TEMP_W'(temp_prod >> TEMP_SHIFT);

    assign temp_degrees = temp_neg ? -quot_mag : quot_mag;

endmodule

@@ rtl/core/angle_frame_parser.sv @@
// Top level of the angle frame parser: input register, frame logic, output register.
//
// The block takes one byte per transfer on the input channel (in_valid, in_stall,
// byte_in). While idle it waits for a byte equal to the type register; the next
// eight bytes are the data (roll, pitch, yaw, temperature, each a little-endian
// signed pair) and the byte after them is the checksum. When the checksum equals
// the low eight bits of the sync register plus the type byte plus the data bytes,
// one result transfer follows on the output channel (out_valid, out_stall) with
// the angles times 180 (degrees in Q15) and the temperature divided by 100.
// A bad checksum produces nothing; either way the parser goes back to idle.
// A byte is taken every cycle unless in_stall is high. The accepted checksum byte
// goes through the frame logic into the frame register, and the result through the
// scaling multipliers into the output register. When the receiver stalls, the
// result waits in the output register, a second good frame waits in the frame
// register, and only then does in_stall rise. Reset returns the parser to idle and
// sets the type and sync registers to 0x53 and 0x55. The user must write the
// registers through the cfg port only while idle; the block does not enforce it.
module angle_frame_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [afp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afp_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [afp_pkg::BYTE_W-1:0]          byte_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [afp_pkg::ANGLE_W-1:0]  roll_q15,
    output logic signed [afp_pkg::ANGLE_W-1:0]  pitch_q15,
    output logic signed [afp_pkg::ANGLE_W-1:0]  yaw_q15,
    output logic signed [afp_pkg::TEMP_W-1:0]   temp_degrees
);
    import afp_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0] type_byte_reg;
    logic [BYTE_W-1:0] sync_byte_reg;

    // Input register.
    logic              in_v_reg, in_v_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_accept;

    // Frame stage.
    frm_status_t frm_status;
    frame_t      frame;
    logic        frame_take;

    // Output register.
    logic                      out_v_reg, out_v_next;
    logic                      out_free;
    logic                      out_load;
    logic signed [ANGLE_W-1:0] roll_sc, pitch_sc, yaw_sc;
    logic signed [TEMP_W-1:0]  temp_sc;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [TEMP_W-1:0]  temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_byte_reg <= TYPE_BYTE_RESET;
            sync_byte_reg <= SYNC_BYTE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TYPE_BYTE: type_byte_reg <= cfg_data;
                REG_SYNC_BYTE: sync_byte_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The input register holds a byte until the frame logic takes it.
    assign in_stall  = in_v_reg && !frm_status.byte_take;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_accept)
        begin
            in_v_next = 1'b1;
        end
        else if (frm_status.byte_take)
        begin
            in_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= byte_in;
        end
    end

    afp_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_v_reg),
        .byte_data  (in_byte_reg),
        .type_byte  (type_byte_reg),
        .sync_byte  (sync_byte_reg),
        .frame_take (frame_take),
        .status     (frm_status),
        .frame      (frame)
    );

    afp_scale u_scale (
        .frame        (frame),
        .roll_q15     (roll_sc),
        .pitch_q15    (pitch_sc),
        .yaw_q15      (yaw_sc),
        .temp_degrees (temp_sc)
    );

    // The output register is free when empty or when its result leaves this cycle.
    assign out_free   = !out_v_reg || !out_stall;
    assign frame_take = frm_status.frame_valid && out_free;
    assign out_load   = frame_take;

    always_comb
    begin
        out_v_next = out_v_reg;
        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            roll_reg  <= roll_sc;
            pitch_reg <= pitch_sc;
            yaw_reg   <= yaw_sc;
            temp_reg  <= temp_sc;
        end
    end

    assign out_valid    = out_v_reg;
    assign roll_q15     = roll_reg;
    assign pitch_q15    = pitch_reg;
    assign yaw_q15      = yaw_reg;
    assign temp_degrees = temp_reg;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the angle frame parser: byte stimulus, prediction and result checks.
`timescale 1ns / 1ps

import afp_pkg::*;

// One result of the parser: three angles in degrees Q15 and a temperature in degrees.
typedef struct {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [TEMP_W-1:0]  temp;
} angles_t;

// Tracks the frame state of the parser and keeps the queue of angle results still to arrive.
class frame_scoreboard;
    localparam int CHECK_POS   = 10;
    localparam int ANGLE_GAIN  = 180;
    localparam int TEMP_DIV    = 100;

    logic [BYTE_W-1:0] type_reg;
    logic [BYTE_W-1:0] sync_reg;
    bit                collecting;
    logic [3:0]        frame_pos;
    logic [BYTE_W-1:0] frame_sum;
    logic [BYTE_W-1:0] payload [NUM_DATA_BYTES];
    angles_t           pending_angles [$];
    int                mismatches;
    int                results_seen;
    int                frames_good;
    int                frames_bad;

    function new();
        type_reg     = TYPE_BYTE_RESET;
        sync_reg     = SYNC_BYTE_RESET;
        collecting   = 0;
        frame_pos    = 1;
        frame_sum    = '0;
        mismatches   = 0;
        results_seen = 0;
        frames_good  = 0;
        frames_bad   = 0;
        foreach (payload[i])
            payload[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        if (idx == REG_TYPE_BYTE)
            type_reg = val;
        else if (idx == REG_SYNC_BYTE)
            sync_reg = val;
    endfunction

    function int pending();
        return pending_angles.size();
    endfunction

    function logic signed [RAW_W-1:0] raw_pair(int lo);
        return {payload[lo + 1], payload[lo]};
    endfunction

    function logic signed [ANGLE_W-1:0] scaled_angle(int lo);
        int v;
        v = int'(raw_pair(lo)) * ANGLE_GAIN;
        return v[ANGLE_W-1:0];
    endfunction

    // Notes one accepted byte; a frame whose checksum matches queues one result.
    function void take_byte(logic [BYTE_W-1:0] b);
        angles_t a;
        int      t;
        if (!collecting) begin
            if (b == type_reg) begin
                collecting = 1;
                frame_sum  = sync_reg + b;
                frame_pos  = 2;
            end
            return;
        end
        if (frame_pos >= 2 && frame_pos < CHECK_POS) begin
            payload[frame_pos - 2] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 1;
            return;
        end
        collecting = 0;
        frame_pos  = 1;
        if (b != frame_sum) begin
            frames_bad++;
            return;
        end
        frames_good++;
        a.roll  = scaled_angle(0);
        a.pitch = scaled_angle(2);
        a.yaw   = scaled_angle(4);
        t = int'(raw_pair(6)) / TEMP_DIV;
        a.temp  = t[TEMP_W-1:0];
        pending_angles.push_back(a);
    endfunction

    // Compares one accepted result with the oldest queued one.
    function void check_result(angles_t got);
        angles_t want;
        results_seen++;
        if (pending_angles.size() == 0) begin
            $display("%0t: result with none queued: roll %0d pitch %0d yaw %0d temp %0d",
                     $time, got.roll, got.pitch, got.yaw, got.temp);
            mismatches++;
            return;
        end
        want = pending_angles.pop_front();
        if (got.roll !== want.roll) begin
            $display("%0t: roll expected %0d, got %0d", $time, want.roll, got.roll);
            mismatches++;
        end
        if (got.pitch !== want.pitch) begin
            $display("%0t: pitch expected %0d, got %0d", $time, want.pitch, got.pitch);
            mismatches++;
        end
        if (got.yaw !== want.yaw) begin
            $display("%0t: yaw expected %0d, got %0d", $time, want.yaw, got.yaw);
            mismatches++;
        end
        if (got.temp !== want.temp) begin
            $display("%0t: temp expected %0d, got %0d", $time, want.temp, got.temp);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    // Spare cycles after the last queued result cover the frame and output
    // registers before any register write.
    localparam int SETTLE_CYCLES = 6;
    // The limit sits well above the slowest correct run, even with every
    // byte waiting out a full gap burst and every result a full stall burst.
    localparam int LIMIT_CYCLES  = 300000;
    localparam int PHASE_BYTES   = 200;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_TYPE_BYTE;
    logic [BYTE_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [BYTE_W-1:0]        byte_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [ANGLE_W-1:0] roll_q15;
    logic signed [ANGLE_W-1:0] pitch_q15;
    logic signed [ANGLE_W-1:0] yaw_q15;
    logic signed [TEMP_W-1:0]  temp_degrees;

    frame_scoreboard   sb;
    // The stimulus side keeps its own copy of the registers to build frames.
    logic [BYTE_W-1:0] cur_type = TYPE_BYTE_RESET;
    logic [BYTE_W-1:0] cur_sync = SYNC_BYTE_RESET;
    bit                idle_on = 1'b1;
    int                gap_odds = 4;
    int                stall_left = 0;
    int                cycle_count = 0;
    int                bytes_sent = 0;
    int                settings_used = 1;

    angle_frame_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .roll_q15     (roll_q15),
        .pitch_q15    (pitch_q15),
        .yaw_q15      (yaw_q15),
        .temp_degrees (temp_degrees)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. A hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("angle_frame_parser regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure in random stall bursts; when idling is
    // switched off the receiver takes every result at once.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            out_stall  <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Result monitor. Signals read here still hold their values from before
    // the edge, so the transfer condition is free of races with the block.
    always @(posedge clk)
    begin
        angles_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.roll  = roll_q15;
            got.pitch = pitch_q15;
            got.yaw   = yaw_q15;
            got.temp  = temp_degrees;
            sb.check_result(got);
        end
    end

    // Offers one byte, after an optional gap burst, and returns on the edge
    // that accepts it. The predictor sees the byte at that same edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(1, gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    // Holds the sender off until every queued result has come out, then lets
    // the pipeline run dry so that a register write finds the block quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register. The write enable is lowered in a step of its own so
    // that back-to-back writes never assign it twice in one time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        if (idx == REG_TYPE_BYTE)
            cur_type = val;
        else
            cur_sync = val;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Sends a full frame: type byte, four little-endian pairs and a checksum.
    // A bad frame gets a checksum that is off by a nonzero amount. With
    // mid_write set, both registers change partway through the data; the
    // checksum still uses the sync value from the start of the frame.
    task automatic send_frame(input logic [RAW_W-1:0] roll, input logic [RAW_W-1:0] pitch,
                              input logic [RAW_W-1:0] yaw, input logic [RAW_W-1:0] temp,
                              input bit good, input bit mid_write);
        logic [BYTE_W-1:0] fr [10];
        logic [BYTE_W-1:0] sum;
        fr[0] = cur_type;
        {fr[2], fr[1]} = roll;
        {fr[4], fr[3]} = pitch;
        {fr[6], fr[5]} = yaw;
        {fr[8], fr[7]} = temp;
        sum = cur_sync;
        for (int i = 0; i < 9; i++)
            sum = sum + fr[i];
        fr[9] = good ? sum : sum + 8'($urandom_range(1, 255));
        for (int i = 0; i < 10; i++) begin
            if (mid_write && i == 4) begin
                settle();
                write_reg(REG_SYNC_BYTE, 8'($urandom_range(0, 255)));
                write_reg(REG_TYPE_BYTE, 8'($urandom_range(0, 255)));
                settings_used++;
            end
            send_byte(fr[i]);
        end
    endtask

    // Picks a raw pair, leaning on the extremes. Temperatures also get values
    // around the multiples of 100 so that truncation toward zero is exercised.
    function automatic logic [RAW_W-1:0] pick_raw(input bit is_temp);
        logic [RAW_W-1:0] near [8] = '{16'd99, 16'd100, 16'd101, -16'sd99,
                                       -16'sd100, -16'sd101, 16'd32767, -16'sd32767};
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return is_temp ? near[$urandom_range(0, 7)] : 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_frame(input bit good, input bit mid_write);
        send_frame(pick_raw(0), pick_raw(0), pick_raw(0), pick_raw(1), good, mid_write);
    endtask

    // One phase of random traffic. Most of it is well-formed frames with random
    // content; the rest is bad checksums, frames cut short, frames with a
    // register write in the middle, and noise bytes between frames.
    task automatic run_phase(input int n_bytes);
        int               stop_at;
        int               pick;
        logic [BYTE_W-1:0] b;
        stop_at  = bytes_sent + n_bytes;
        gap_odds = $urandom_range(2, 8);
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                random_frame(1'b1, 1'b0);
            end
            else if (pick < 80) begin
                random_frame(1'b0, 1'b0);
            end
            else if (pick < 85) begin
                // A frame cut short: the bytes that follow are taken as its tail.
                send_byte(cur_type);
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 87) begin
                random_frame(1'b1, 1'b1);
            end
            else begin
                repeat ($urandom_range(1, 4)) begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == cur_type);
                    send_byte(b);
                end
            end
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] type_set [4] = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        logic [BYTE_W-1:0] sync_set [4] = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset register values. Noise at both byte
        // extremes first, then a good frame holding the most negative and most
        // positive raw values and a yaw pair made of type bytes (no resync
        // inside a frame), then a frame with a bad checksum.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'h8000, 16'h7FFF, 16'h5353, 16'h8000, 1'b1, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 1'b0, 1'b0);
        // Register writes in the middle of a good frame.
        send_frame(16'h0001, 16'hFFFF, 16'h8000, 16'hFF9D, 1'b1, 1'b1);

        // Fixed extreme settings, then random ones. Each change happens only
        // after every queued result has come out.
        for (int p = 0; p < 4; p++) begin
            settle();
            write_reg(REG_TYPE_BYTE, type_set[p]);
            write_reg(REG_SYNC_BYTE, sync_set[p]);
            settings_used++;
            run_phase(PHASE_BYTES);
        end
        for (int p = 0; p < 3; p++) begin
            settle();
            write_reg(REG_TYPE_BYTE, 8'($urandom_range(0, 255)));
            write_reg(REG_SYNC_BYTE, 8'($urandom_range(0, 255)));
            settings_used++;
            run_phase(PHASE_BYTES);
        end

        // Last stretch at full rate: no gaps from the sender, no stalls.
        settle();
        write_reg(REG_TYPE_BYTE, TYPE_BYTE_RESET);
        write_reg(REG_SYNC_BYTE, SYNC_BYTE_RESET);
        settings_used++;
        idle_on = 1'b0;
        run_phase(PHASE_BYTES);

        settle();
        $display("Sent %0d bytes under %0d register settings.", bytes_sent, settings_used);
        $display("Frames accepted %0d, rejected on checksum %0d, results checked %0d.",
                 sb.frames_good, sb.frames_bad, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("angle_frame_parser regression: pass");
        end
        else begin
            $display("angle_frame_parser regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/afp_pkg.sv
rtl/core/afp_frame.sv
rtl/core/afp_scale.sv
rtl/core/angle_frame_parser.sv
bench/tb_top.sv
